### rtl/gkce_pkg.sv
// Shared constants and types for the key change event scanner.
package gkce_pkg;

  localparam int LINES      = 32;
  localparam int LINE_W     = 5;
  localparam int CODE_WIDTH = 10;
  localparam int IN_BITS    = LINES + LINE_W + CODE_WIDTH;
  localparam int IN_W       = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = CODE_WIDTH + LINE_W + 1;
  localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_LOAD   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } scan_state_t;

  typedef struct packed {
    logic             go;
    logic [LINES-1:0] change;
    logic [LINES-1:0] levels;
  } scan_start_t;

endpackage

### rtl/gpio_key_change_event_scanner_top.sv
// Top level of the polled key change event scanner.
// Usage:
//   Input channel (in_*): one beat per item. in_tuser selects the kind:
//   a sample of 32 active-low line levels, or a load of one line's key code.
//   A load writes the code table, enables the line and forces the next
//   sample to only capture a new baseline.
//   Output channel (out_*): one beat per changed line of a sample, in
//   ascending line order; out_tlast marks the final event of that sample.
// Flow:
//   Loads and rebasing samples start no scan; a sample without changes
//   passes through the scan state once. A sample with changes walks the
//   change vector one bit per cycle while not stalled, up to its highest changed
//   line, and waits in the emit state at each event for the registered code table
//   read; in_tready stays low until the scan ends. The shift and read set this.
//   in_tready is high whenever the scanner is idle, also while the last
//   event still waits in the output register.
// Reset: synchronous, active low; clears enables, baseline and valid flag.
//   The code table is not cleared; only codes of written lines are emitted.
// Stall: a low out_tready while an event is held freezes the scan at the next event, kept pending.
module gpio_key_change_event_scanner_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // tdata: line_levels[31:0], entry_line[36:32], entry_code[46:37], zero fill
  input  logic [gkce_pkg::IN_W-1:0]   in_tdata,
  // tuser: kind
  input  logic                        in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // tdata: event_code[9:0], event_line[14:10], pressed[15]
  output logic [gkce_pkg::OUT_W-1:0]  out_tdata,
  output logic                        out_tlast
);

  localparam int LV_LO = 0;
  localparam int EL_LO = gkce_pkg::LINES;
  localparam int EC_LO = gkce_pkg::LINES + gkce_pkg::LINE_W;

  logic [gkce_pkg::LINES-1:0] enabled_r;
  logic [gkce_pkg::LINES-1:0] baseline_r;
  logic                       base_valid_r;

  logic                            accept;
  logic                            is_load;
  logic                            scan_idle;
  logic [gkce_pkg::LINES-1:0]      levels;
  logic [gkce_pkg::LINES-1:0]      masked;
  logic [gkce_pkg::LINE_W-1:0]     entry_line;
  logic [gkce_pkg::CODE_WIDTH-1:0] entry_code;
  logic [gkce_pkg::LINE_W-1:0]     ram_raddr;
  logic [gkce_pkg::CODE_WIDTH-1:0] ram_rdata;
  gkce_pkg::scan_start_t           start;

  // unpack the input beat
  assign levels     = in_tdata[LV_LO +: gkce_pkg::LINES];
  assign entry_line = in_tdata[EL_LO +: gkce_pkg::LINE_W];
  assign entry_code = in_tdata[EC_LO +: gkce_pkg::CODE_WIDTH];

  assign in_tready = scan_idle;
  assign accept    = in_tvalid && in_tready;
  assign is_load   = (in_tuser == gkce_pkg::KIND_LOAD);
  assign masked    = levels & enabled_r;

  // launch a scan only for a sample against a valid baseline
  always_comb begin
    start.go     = accept && !is_load && base_valid_r;
    start.change = masked ^ baseline_r;
    start.levels = masked;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r    <= '0;
      baseline_r   <= '0;
      base_valid_r <= 1'b0;
    end else if (accept) begin
      if (is_load) begin
        enabled_r[entry_line] <= 1'b1;
        base_valid_r          <= 1'b0;
      end else begin
        baseline_r   <= masked;
        base_valid_r <= 1'b1;
      end
    end
  end

  gkce_code_ram u_ram (
    .clk   (clk),
    .we    (accept && is_load),
    .waddr (entry_line),
    .wdata (entry_code),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gkce_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .idle       (scan_idle),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### rtl/gkce_code_ram.sv
// Key code table: one write port, one registered read port.
module gkce_code_ram (
  input  logic                             clk,
  input  logic                             we,
  input  logic [gkce_pkg::LINE_W-1:0]      waddr,
  input  logic [gkce_pkg::CODE_WIDTH-1:0]  wdata,
  input  logic [gkce_pkg::LINE_W-1:0]      raddr,
  output logic [gkce_pkg::CODE_WIDTH-1:0]  rdata
);

  logic [gkce_pkg::CODE_WIDTH-1:0] mem [gkce_pkg::LINES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/gkce_scan.sv
// Bit-serial change scanner with code lookup and output register.
module gkce_scan (
  input  logic                             clk,
  input  logic                             rst_n,
  input  gkce_pkg::scan_start_t            start,
  output logic                             idle,
  output logic [gkce_pkg::LINE_W-1:0]      ram_raddr,
  input  logic [gkce_pkg::CODE_WIDTH-1:0]  ram_rdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [gkce_pkg::OUT_W-1:0]       out_tdata,
  output logic                             out_tlast
);

  gkce_pkg::scan_state_t state_r, state_nxt;

  logic [gkce_pkg::LINES-1:0]      change_sr_r;
  logic [gkce_pkg::LINES-1:0]      levels_sr_r;
  logic [gkce_pkg::LINE_W-1:0]     cnt_r;
  logic                            out_valid_r;
  logic [gkce_pkg::CODE_WIDTH-1:0] out_code_r;
  logic [gkce_pkg::LINE_W-1:0]     out_line_r;
  logic                            out_pressed_r;
  logic                            out_last_r;

  logic can_load;
  logic load;
  logic shift;
  logic is_last;

  assign can_load  = !out_valid_r || out_tready;
  assign is_last   = (change_sr_r[gkce_pkg::LINES-1:1] == '0);
  assign ram_raddr = cnt_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gkce_pkg::ST_IDLE: begin
        if (start.go) state_nxt = gkce_pkg::ST_SCAN;
      end
      gkce_pkg::ST_SCAN: begin
        if (change_sr_r == '0)  state_nxt = gkce_pkg::ST_IDLE;
        else if (change_sr_r[0]) state_nxt = gkce_pkg::ST_EMIT;
      end
      gkce_pkg::ST_EMIT: begin
        if (can_load) state_nxt = is_last ? gkce_pkg::ST_IDLE : gkce_pkg::ST_SCAN;
      end
      default: state_nxt = gkce_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    idle  = 1'b0;
    load  = 1'b0;
    shift = 1'b0;
    case (state_r)
      gkce_pkg::ST_IDLE: idle = 1'b1;
      gkce_pkg::ST_SCAN: shift = !change_sr_r[0];
      gkce_pkg::ST_EMIT: begin
        load  = can_load;
        shift = can_load;
      end
      default: idle = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gkce_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start.go && state_r == gkce_pkg::ST_IDLE) begin
      change_sr_r <= start.change;
      levels_sr_r <= start.levels;
      cnt_r       <= '0;
    end else if (shift) begin
      change_sr_r <= change_sr_r >> 1;
      levels_sr_r <= levels_sr_r >> 1;
      cnt_r       <= cnt_r + 1'b1;
    end
    if (load) begin
      out_code_r    <= ram_rdata;
      out_line_r    <= cnt_r;
      out_pressed_r <= !levels_sr_r[0];
      out_last_r    <= is_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = gkce_pkg::OUT_W'({out_pressed_r, out_line_r, out_code_r});

  a_emit_on_change: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gkce_pkg::ST_EMIT) |-> change_sr_r[0])
    else $error("emit state without a pending changed line");

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start.go |-> (state_r == gkce_pkg::ST_IDLE))
    else $error("scan started while busy");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gkce_pkg::ST_SCAN && change_sr_r == '0) |=> idle)
    else $error("scanner did not finish on an empty change vector");

endmodule
